[sv/tlcf_pkg.sv]
// Package for the simplified TCP connection endpoint.
// Holds state and event codes, the result record and its builders.
// No dependencies.
`default_nettype none
package tlcf_pkg;

  localparam int MAX_SEGMENT = 536;
  localparam int RECV_WINDOW = 3072;

  localparam int LEN_W = 10;
  localparam int WIN_W = 12;
  localparam int MAX_RES = 4;

  localparam logic [LEN_W-1:0] MAX_SEG_LEN = LEN_W'(MAX_SEGMENT);
  localparam logic [WIN_W-1:0] RECV_WIN = WIN_W'(RECV_WINDOW);

  localparam logic REG_OPEN_ACTIVE = 1'b0;
  localparam logic REG_INITIAL_SEQ = 1'b1;

  localparam logic [7:0] F_FIN = 8'h01;
  localparam logic [7:0] F_SYN = 8'h02;
  localparam logic [7:0] F_ACK = 8'h10;

  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_SEG   = 2'd2;
  localparam logic [1:0] CMD_CLOSE = 2'd3;

  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_DELIVER = 2'd1;
  localparam logic [1:0] KIND_FIN     = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [2:0] ERR_HANDSHAKE  = 3'd1;
  localparam logic [2:0] ERR_CLOSE_WAIT = 3'd2;
  localparam logic [2:0] ERR_NOT_ACK    = 3'd3;
  localparam logic [2:0] ERR_BAD_CLOSE  = 3'd4;
  localparam logic [2:0] ERR_OVER_WIN   = 3'd5;
  localparam logic [2:0] ERR_ZERO_WIN   = 3'd6;

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_SYN_SENT   = 4'd1;
  localparam logic [3:0] ST_LISTEN     = 4'd2;
  localparam logic [3:0] ST_SYN_RCVD   = 4'd3;
  localparam logic [3:0] ST_EST        = 4'd4;
  localparam logic [3:0] ST_FIN_WAIT1  = 4'd5;
  localparam logic [3:0] ST_FIN_WAIT2  = 4'd6;
  localparam logic [3:0] ST_CLOSING    = 4'd7;
  localparam logic [3:0] ST_CLOSE_WAIT = 4'd8;
  localparam logic [3:0] ST_LAST_ACK   = 4'd9;
  localparam logic [3:0] ST_CLOSED     = 4'd10;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       flags;
    logic [31:0]      seq;
    logic [31:0]      ack;
    logic [WIN_W-1:0] window;
    logic [LEN_W-1:0] len;
    logic [2:0]       err;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [2:0]         cnt;
    logic               done;
  } bundle_t;

  function automatic res_t mk_seg(input logic [7:0] f, input logic [31:0] sq,
                                  input logic [31:0] ak, input logic [WIN_W-1:0] w,
                                  input logic [LEN_W-1:0] l);
    res_t r;
    r.kind   = KIND_SEND;
    r.flags  = f;
    r.seq    = sq;
    r.ack    = ak;
    r.window = w;
    r.len    = (f != 8'h00) ? '0 : l;
    r.err    = '0;
    return r;
  endfunction

  function automatic res_t mk_note(input logic [1:0] k, input logic [LEN_W-1:0] l);
    res_t r;
    r        = '0;
    r.kind   = k;
    r.len    = l;
    return r;
  endfunction

  function automatic res_t mk_err(input logic [2:0] code);
    res_t r;
    r      = '0;
    r.kind = KIND_ERROR;
    r.err  = code;
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/tlcf_front.sv]
// Front end: accepts events, keeps the connection state and builds the
// results of each event as one bundle. Depends on tlcf_pkg.
`default_nettype none
module tlcf_front
  import tlcf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_index,
  input  wire logic [7:0]       cfg_data,
  input  wire logic             accept,
  input  wire logic [1:0]       cmd,
  input  wire logic [7:0]       seg_flags,
  input  wire logic [31:0]      seg_seq,
  input  wire logic [31:0]      seg_ack,
  input  wire logic [15:0]      seg_window,
  input  wire logic [LEN_W-1:0] payload_len,
  output logic                  push,
  output bundle_t               bundle
);

  logic        open_active;
  logic [7:0]  initial_seq;
  logic [3:0]  conn_state, conn_state_next;
  logic [31:0] send_seq, send_seq_next;
  logic [31:0] recv_ack, recv_ack_next;
  logic [15:0] peer_window, peer_window_next;
  logic        done_flag, done_flag_next;

  logic [LEN_W-1:0] pl;
  logic [WIN_W-1:0] fw;
  logic [31:0]      ack_inc, ack_base, ack_new;
  logic             fl_ack, fl_syn, fl_fin;
  res_t [MAX_RES-1:0] res;
  logic [2:0]       n;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_active <= 1'b0;
      initial_seq <= 8'd1;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_OPEN_ACTIVE) begin
        open_active <= cfg_data[0];
      end else begin
        initial_seq <= cfg_data;
      end
    end
  end

  always_comb begin
    pl       = (payload_len > MAX_SEG_LEN) ? MAX_SEG_LEN : payload_len;
    fw       = RECV_WIN - WIN_W'(pl);
    fl_ack   = (seg_flags & F_ACK) != 8'h00;
    fl_syn   = (seg_flags & F_SYN) != 8'h00;
    fl_fin   = (seg_flags & F_FIN) != 8'h00;
    if (seg_flags == F_ACK) begin
      ack_inc = '0;
    end else if (seg_flags != 8'h00) begin
      ack_inc = 32'd1;
    end else begin
      ack_inc = 32'(pl);
    end
    ack_base = (conn_state == ST_SYN_SENT || conn_state == ST_LISTEN) ? seg_seq : recv_ack;
    ack_new  = ack_base + ack_inc;

    conn_state_next  = conn_state;
    send_seq_next    = send_seq;
    recv_ack_next    = recv_ack;
    peer_window_next = peer_window;
    done_flag_next   = done_flag;
    res              = '0;
    n                = '0;

    case (cmd)
      CMD_OPEN: begin
        if (conn_state == ST_IDLE) begin
          send_seq_next = 32'(initial_seq);
          if (open_active) begin
            res[0]          = mk_seg(F_SYN, 32'(initial_seq), recv_ack, RECV_WIN, '0);
            n               = 3'd1;
            send_seq_next   = 32'(initial_seq) + 32'd1;
            conn_state_next = ST_SYN_SENT;
          end else begin
            conn_state_next = ST_LISTEN;
          end
        end
      end
      CMD_DATA: begin
        if (conn_state == ST_EST) begin
          n = 3'd1;
          if (16'(pl) > peer_window) begin
            res[0] = mk_err(ERR_OVER_WIN);
          end else begin
            res[0]        = mk_seg(8'h00, send_seq, recv_ack, RECV_WIN, pl);
            send_seq_next = send_seq + 32'(pl);
          end
        end
      end
      CMD_CLOSE: begin
        n = 3'd1;
        if (conn_state == ST_EST || conn_state == ST_CLOSE_WAIT) begin
          res[0]          = mk_seg(F_FIN, send_seq, recv_ack, RECV_WIN, '0);
          send_seq_next   = send_seq + 32'd1;
          conn_state_next = (conn_state == ST_EST) ? ST_FIN_WAIT1 : ST_LAST_ACK;
        end else begin
          res[0] = mk_err(ERR_BAD_CLOSE);
        end
      end
      default: begin
        case (conn_state)
          ST_SYN_SENT: begin
            n = 3'd1;
            if (seg_ack != send_seq) begin
              res[0] = mk_err(ERR_HANDSHAKE);
            end else begin
              recv_ack_next    = ack_new;
              peer_window_next = seg_window;
              res[0]           = mk_seg(F_ACK, send_seq, ack_new, RECV_WIN, '0);
              conn_state_next  = ST_EST;
            end
          end
          ST_LISTEN: begin
            n = 3'd1;
            if (!fl_syn) begin
              res[0] = mk_err(ERR_HANDSHAKE);
            end else begin
              recv_ack_next    = ack_new;
              peer_window_next = seg_window;
              res[0]           = mk_seg(F_SYN | F_ACK, send_seq, ack_new, RECV_WIN, '0);
              send_seq_next    = send_seq + 32'd1;
              conn_state_next  = ST_SYN_RCVD;
            end
          end
          ST_SYN_RCVD: begin
            if (seg_seq != recv_ack || seg_ack != send_seq || !fl_ack) begin
              res[0] = mk_err(ERR_HANDSHAKE);
              n      = 3'd1;
            end else begin
              recv_ack_next    = ack_new;
              peer_window_next = seg_window;
              conn_state_next  = ST_EST;
            end
          end
          ST_EST, ST_FIN_WAIT1, ST_FIN_WAIT2, ST_CLOSING, ST_CLOSE_WAIT, ST_LAST_ACK: begin
            if (seg_window == 16'd0) begin
              res[0] = mk_err(ERR_ZERO_WIN);
              n      = 3'd1;
            end else if (conn_state == ST_CLOSE_WAIT) begin
              res[0] = mk_err(ERR_CLOSE_WAIT);
              n      = 3'd1;
            end else if (conn_state == ST_CLOSING && !fl_ack) begin
              res[0] = mk_err(ERR_NOT_ACK);
              n      = 3'd1;
            end else begin
              peer_window_next = seg_window;
              recv_ack_next    = ack_new;
              case (conn_state)
                ST_EST: begin
                  if (fl_fin) begin
                    conn_state_next = ST_CLOSE_WAIT;
                    res[0] = mk_seg(F_ACK, send_seq, ack_new, fw, '0);
                    res[1] = mk_note(KIND_FIN, '0);
                    res[2] = mk_seg(F_ACK, send_seq, ack_new, fw, '0);
                    n      = 3'd3;
                  end else if (seg_flags != F_ACK) begin
                    res[0] = mk_seg(F_ACK, send_seq, ack_new, fw, '0);
                    n      = 3'd1;
                  end
                end
                ST_FIN_WAIT1: begin
                  if (fl_ack) begin
                    conn_state_next = ST_FIN_WAIT2;
                    res[0] = mk_note(KIND_FIN, '0);
                    n      = 3'd1;
                  end else if (fl_fin) begin
                    conn_state_next = ST_CLOSING;
                    res[0] = mk_seg(F_ACK, send_seq, ack_new, fw, '0);
                    res[1] = mk_note(KIND_FIN, '0);
                    n      = 3'd2;
                  end
                end
                ST_FIN_WAIT2: begin
                  if (fl_fin) begin
                    res[0]          = mk_seg(F_ACK, send_seq, ack_new, fw, '0);
                    n               = 3'd1;
                    conn_state_next = ST_CLOSED;
                    done_flag_next  = 1'b1;
                  end
                end
                default: begin
                  if (fl_ack) begin
                    conn_state_next = ST_CLOSED;
                    done_flag_next  = 1'b1;
                  end
                end
              endcase
              if (pl != '0) begin
                res[n[1:0]] = mk_note(KIND_DELIVER, pl);
                n           = n + 3'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_state  <= ST_IDLE;
      send_seq    <= '0;
      recv_ack    <= '0;
      peer_window <= '0;
      done_flag   <= 1'b0;
    end else if (accept) begin
      conn_state  <= conn_state_next;
      send_seq    <= send_seq_next;
      recv_ack    <= recv_ack_next;
      peer_window <= peer_window_next;
      done_flag   <= done_flag_next;
    end
  end

  assign push        = accept && (n != 3'd0);
  assign bundle.res  = res;
  assign bundle.cnt  = n;
  assign bundle.done = done_flag_next;

endmodule
`default_nettype wire

[sv/tlcf_queue.sv]
// Two-entry queue of result bundles between the front and back ends.
// Depends on tlcf_pkg.
`default_nettype none
module tlcf_queue
  import tlcf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  bundle_t      push_data,
  input  wire logic    pop,
  output logic         full,
  output logic         not_empty,
  output bundle_t      head
);

  bundle_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = entry[rd_ptr];

endmodule
`default_nettype wire

[sv/tlcf_back.sv]
// Back end: steps through the results of the head bundle, one word per cycle while out_ready is high.
// Depends on tlcf_pkg.
`default_nettype none
module tlcf_back
  import tlcf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  head_valid,
  input  bundle_t    head,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res,
  output logic       out_done,
  output logic       out_last
);

  logic [1:0] idx;

  assign out_valid = head_valid;
  assign out_res   = head.res[idx];
  assign out_done  = head.done;
  assign out_last  = ({1'b0, idx} + 3'd1) == head.cnt;
  assign pop       = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_valid && out_ready) begin
      idx <= out_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

[sv/tcp_lite_connection_fsm_top.sv]
// Top level of the simplified TCP connection endpoint.
// An accepted event's results are registered in the queue as one bundle before its first word is offered.
// Result words leave one per cycle while m_tready is high; an event yields 0 to 4 results.
// Events are taken every cycle while the two-bundle result queue has room.
// Reset: state IDLE, sequence and acknowledge numbers zero, passive open,
// initial_seq 1, queue empty. Depends on tlcf_pkg, tlcf_front, tlcf_queue, tlcf_back.
`default_nettype none
module tcp_lite_connection_fsm_top
  import tlcf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_index,
  input  wire logic [7:0]   cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // seg_flags, seg_seq, seg_ack, seg_window, payload_len, zero fill
  input  wire logic [103:0] s_tdata,
  // cmd
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_flags, out_seq, out_ack, out_window, out_len, err_code, conn_done, zero fill
  output logic [103:0]      m_tdata,
  // kind
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  logic    accept;
  logic    push;
  bundle_t bundle;
  logic    q_full;
  logic    q_valid;
  bundle_t q_head;
  logic    pop;
  res_t    out_res;
  logic    out_done;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  tlcf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .cmd         (s_tuser),
    .seg_flags   (s_tdata[7:0]),
    .seg_seq     (s_tdata[39:8]),
    .seg_ack     (s_tdata[71:40]),
    .seg_window  (s_tdata[87:72]),
    .payload_len (s_tdata[97:88]),
    .push        (push),
    .bundle      (bundle)
  );

  tlcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (bundle),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tlcf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res),
    .out_done   (out_done),
    .out_last   (m_tlast)
  );

  assign m_tuser = out_res.kind;
  assign m_tdata = {6'b0, out_done, out_res.err, out_res.len, out_res.window,
                    out_res.ack, out_res.seq, out_res.flags};

endmodule
`default_nettype wire
